// File: rtl/core/hbt_pkg.sv
// package for the bimodal histogram threshold block
// types, constants and codes shared by controller, datapath and top level
// no dependencies
package hbt_pkg;

    localparam int BIN_W   = 15;          // histogram bin width
    localparam int SUM_W   = 23;          // 256 bins of 32767 fit in 23 bits
    localparam int IDX_W   = 9;           // bin index plus one above bin 255
    localparam int MISS_W  = 9;           // non-rise counter
    localparam int CFG_W   = 8;           // widest configuration register
    localparam int BINS    = 256;

    localparam logic [BIN_W-1:0] BIN_MAX     = 15'h7FFF;
    localparam logic [SUM_W-1:0] DELTA_START = 23'd10000;

    localparam logic [CFG_W-1:0] DARK_END_RST     = 8'd100;
    localparam logic [CFG_W-1:0] BRIGHT_START_RST = 8'd254;
    localparam logic [CFG_W-1:0] BRIGHT_END_RST   = 8'd150;
    localparam logic [CFG_W-1:0] PATIENCE_RST     = 8'd10;

    typedef enum logic [1:0] {
        CFG_DARK_END,
        CFG_BRIGHT_START,
        CFG_BRIGHT_END,
        CFG_PATIENCE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_BRIGHT,
        IDX_LO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_DARK_RD,
        ST_DARK_EV,
        ST_BRT_RD,
        ST_BRT_EV,
        ST_SUM_RD,
        ST_SUM_EV,
        ST_BAL_RD,
        ST_BAL_EV,
        ST_BAL_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic    accept;       // pixel item taken this cycle
        logic    rd;           // read histogram at scan index
        t_idx_op idx_op;
        logic    peak_init;    // peaks to their defaults
        logic    scan_clr;     // restart a peak scan
        logic    scan_ev;      // evaluate one peak scan step
        logic    scan_bright;  // step belongs to the bright scan
        logic    sum_clr;      // clear balance accumulators
        logic    sum_ev;       // add bin to the total
        logic    bal_ev;       // move bin from above to below
        logic    bal_cmp;      // compare balance and pick threshold
    } t_cmd;

    typedef struct packed {
        logic dark_go;
        logic bright_go;
        logic stop;
        logic bal_ok;
        logic sum_go;
        logic bal_go;
    } t_sts;

endpackage

// File: rtl/core/hbt_ctrl.sv
// controller state machine of the bimodal histogram threshold block
// sequences pixel counting, both peak scans and the balance search
// depends on hbt_pkg
module hbt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_frame_last,
    input  hbt_pkg::t_sts i_sts,
    output hbt_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_valid
);
    import hbt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept  = i_start && (r_state == ST_IDLE);
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_frame_last) n_state = ST_FLUSH;
            end
            ST_FLUSH:   n_state = ST_DARK_RD;
            ST_DARK_RD: n_state = i_sts.dark_go ? ST_DARK_EV : ST_BRT_RD;
            ST_DARK_EV: n_state = i_sts.stop ? ST_BRT_RD : ST_DARK_RD;
            ST_BRT_RD:  n_state = i_sts.bright_go ? ST_BRT_EV : ST_SUM_RD;
            ST_BRT_EV:  n_state = i_sts.stop ? ST_SUM_RD : ST_BRT_RD;
            ST_SUM_RD: begin
                if (i_sts.sum_go)      n_state = ST_SUM_EV;
                else if (i_sts.bal_ok) n_state = ST_BAL_RD;
                else                   n_state = ST_DONE;
            end
            ST_SUM_EV:  n_state = ST_SUM_RD;
            ST_BAL_RD:  n_state = i_sts.bal_go ? ST_BAL_EV : ST_DONE;
            ST_BAL_EV:  n_state = ST_BAL_CMP;
            ST_BAL_CMP: n_state = ST_BAL_RD;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd        = '0;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.accept = accept;
        case (r_state)
            ST_FLUSH: begin
                o_cmd.idx_op    = IDX_ZERO;
                o_cmd.peak_init = 1'b1;
                o_cmd.scan_clr  = 1'b1;
            end
            ST_DARK_RD: begin
                if (i_sts.dark_go) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    o_cmd.idx_op   = IDX_BRIGHT;
                    o_cmd.scan_clr = 1'b1;
                end
            end
            ST_DARK_EV: begin
                o_cmd.scan_ev = 1'b1;
                if (i_sts.stop) begin
                    o_cmd.idx_op   = IDX_BRIGHT;
                    o_cmd.scan_clr = 1'b1;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                end
            end
            ST_BRT_RD: begin
                if (i_sts.bright_go) begin
                    o_cmd.rd = 1'b1;
                end else begin
                    o_cmd.idx_op  = IDX_LO;
                    o_cmd.sum_clr = 1'b1;
                end
            end
            ST_BRT_EV: begin
                o_cmd.scan_ev     = 1'b1;
                o_cmd.scan_bright = 1'b1;
                if (i_sts.stop) begin
                    o_cmd.idx_op  = IDX_LO;
                    o_cmd.sum_clr = 1'b1;
                end else begin
                    o_cmd.idx_op = IDX_DEC;
                end
            end
            ST_SUM_RD: begin
                if (i_sts.sum_go)      o_cmd.rd = 1'b1;
                else if (i_sts.bal_ok) o_cmd.idx_op = IDX_LO;
            end
            ST_SUM_EV: begin
                o_cmd.sum_ev = 1'b1;
                o_cmd.idx_op = IDX_INC;
            end
            ST_BAL_RD: begin
                if (i_sts.bal_go) o_cmd.rd = 1'b1;
            end
            ST_BAL_EV: begin
                o_cmd.bal_ev = 1'b1;
            end
            ST_BAL_CMP: begin
                o_cmd.bal_cmp = 1'b1;
                o_cmd.idx_op  = IDX_INC;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/hbt_datapath.sv
// datapath of the bimodal histogram threshold block
// histogram memory with valid bits, peak scan and balance search registers
// depends on hbt_pkg
module hbt_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hbt_pkg::t_cmd             i_cmd,
    output hbt_pkg::t_sts             o_sts,
    input  logic [7:0]                i_pixel,
    input  logic                      i_frame_last,
    input  logic                      i_cfg_we,
    input  hbt_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [hbt_pkg::CFG_W-1:0] i_cfg_data,
    output logic [7:0]                o_threshold,
    output logic [7:0]                o_dark_peak,
    output logic [7:0]                o_bright_peak
);
    import hbt_pkg::*;

    // histogram store, cleared per frame through the valid bits
    logic [BIN_W-1:0] mem [BINS];
    logic [BINS-1:0]  r_valid;
    logic             r_frame_started;

    // configuration
    logic [CFG_W-1:0] r_dark_end;
    logic [CFG_W-1:0] r_bright_start;
    logic [CFG_W-1:0] r_bright_end;
    logic [CFG_W-1:0] r_patience;

    // read port
    logic [BIN_W-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [7:0]       rd_addr;
    logic             n_rd_vld;

    // increment stage
    logic             r_b_vld;
    logic [7:0]       r_b_pix;
    logic             r_fwd;
    logic [BIN_W-1:0] r_wdata;
    logic [BIN_W-1:0] bin_val;
    logic [BIN_W-1:0] hist_val;
    logic [BIN_W-1:0] n_bin;

    // scans
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_first;
    logic [MISS_W-1:0] r_misses;
    logic [MISS_W-1:0] n_misses;
    logic [BIN_W-1:0]  r_prev;
    logic              rise;
    logic [7:0]        r_dark;
    logic [7:0]        r_bright;

    // balance search
    logic [SUM_W-1:0] r_above;
    logic [SUM_W-1:0] r_below;
    logic [SUM_W-1:0] r_delta;
    logic [SUM_W:0]   diff;
    logic [SUM_W-1:0] abs_diff;
    logic [7:0]       r_thr;

    assign rd_addr  = i_cmd.accept ? i_pixel : r_idx[7:0];
    assign n_rd_vld = i_cmd.accept ? (r_frame_started & r_valid[i_pixel])
                                   : (~r_idx[IDX_W-1] & r_valid[r_idx[7:0]]);

    assign bin_val  = r_rd_vld ? r_rd_data : '0;
    assign hist_val = r_fwd ? r_wdata : bin_val;
    assign n_bin    = (hist_val == BIN_MAX) ? hist_val : hist_val + BIN_W'(1);

    assign rise     = bin_val > r_prev;
    assign n_misses = r_first ? '0 : (rise ? '0 : r_misses + MISS_W'(1));

    assign diff     = {1'b0, r_above} - {1'b0, r_below};
    assign abs_diff = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];

    always_comb begin
        case (i_cmd.idx_op)
            IDX_ZERO:   n_idx = '0;
            IDX_BRIGHT: n_idx = {1'b0, r_bright_start} + IDX_W'(1);
            IDX_LO:     n_idx = {1'b0, r_dark};
            IDX_INC:    n_idx = r_idx + IDX_W'(1);
            IDX_DEC:    n_idx = r_idx - IDX_W'(1);
            default:    n_idx = r_idx;
        endcase
    end

    always_comb begin
        o_sts.dark_go   = (r_idx < {1'b0, r_dark_end}) && (r_dark_end >= 8'd2);
        o_sts.bright_go = r_first ? (r_bright_start > r_bright_end)
                                  : (r_idx > {1'b0, r_bright_end});
        o_sts.stop      = ~r_first && (n_misses > {1'b0, r_patience});
        o_sts.bal_ok    = r_dark < r_bright;
        o_sts.sum_go    = (r_dark < r_bright) && (r_idx <= {1'b0, r_bright});
        o_sts.bal_go    = r_idx < {1'b0, r_bright};
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (r_b_vld) mem[r_b_pix] <= n_bin;
        if (i_cmd.accept || i_cmd.rd) r_rd_data <= mem[rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid         <= '0;
            r_frame_started <= 1'b0;
            r_b_vld         <= 1'b0;
            r_thr           <= '0;
            r_dark_end      <= DARK_END_RST;
            r_bright_start  <= BRIGHT_START_RST;
            r_bright_end    <= BRIGHT_END_RST;
            r_patience      <= PATIENCE_RST;
        end else begin
            r_b_vld <= i_cmd.accept;
            if (i_cmd.accept) r_frame_started <= ~i_frame_last;
            if (i_cmd.accept && !r_frame_started) begin
                r_valid <= '0;
            end else if (r_b_vld) begin
                r_valid[r_b_pix] <= 1'b1;
            end
            if (i_cmd.bal_cmp && (abs_diff < r_delta)) r_thr <= r_idx[7:0];
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DARK_END:     r_dark_end     <= i_cfg_data;
                    CFG_BRIGHT_START: r_bright_start <= i_cfg_data;
                    CFG_BRIGHT_END:   r_bright_end   <= i_cfg_data;
                    CFG_PATIENCE:     r_patience     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept || i_cmd.rd) r_rd_vld <= n_rd_vld;
        r_idx    <= n_idx;
        if (i_cmd.accept) begin
            r_b_pix <= i_pixel;
            r_fwd   <= r_b_vld && (r_b_pix == i_pixel);
        end
        if (r_b_vld) r_wdata <= n_bin;

        if (i_cmd.peak_init) begin
            r_dark   <= '0;
            r_bright <= 8'hFF;
        end
        if (i_cmd.scan_clr) begin
            r_first  <= 1'b1;
            r_misses <= '0;
        end else if (i_cmd.scan_ev) begin
            r_first  <= 1'b0;
            r_misses <= n_misses;
            r_prev   <= bin_val;
            if (!r_first && rise) begin
                if (i_cmd.scan_bright) r_bright <= r_idx[7:0];
                else                   r_dark   <= r_idx[7:0];
            end
        end

        if (i_cmd.sum_clr) begin
            r_above <= '0;
            r_below <= '0;
            r_delta <= DELTA_START;
        end else if (i_cmd.sum_ev) begin
            r_above <= r_above + SUM_W'(bin_val);
        end else if (i_cmd.bal_ev) begin
            r_above <= r_above - SUM_W'(bin_val);
            r_below <= r_below + SUM_W'(bin_val);
        end else if (i_cmd.bal_cmp) begin
            r_delta <= abs_diff;
        end
    end

    assign o_threshold   = r_thr;
    assign o_dark_peak   = r_dark;
    assign o_bright_peak = r_bright;

endmodule

// File: rtl/core/histogram_bimodal_threshold.sv
// top level of the bimodal histogram threshold block
// joins the controller hbt_ctrl and the datapath hbt_datapath
// depends on hbt_pkg
//
// usage
//  - pixel items arrive on i_pixel / i_frame_last and are taken at a clock
//    edge where start is high and busy is low
//  - while a frame streams in, one pixel item is taken every cycle with start
//    high; busy stays low, each pixel is counted through a read-increment-write
//    pipe of the 256-bin histogram memory with forwarding between equal pixels
//  - the first pixel of a frame clears all bins at once through valid bits
//  - after the item marked i_frame_last, busy rises and the controller runs
//    an upward dark peak scan, a downward bright peak scan, a summing pass
//    and the balance search, all over the single histogram read port
//  - crossed or equal peaks skip both balance passes
//  - the result is on o_threshold / o_dark_peak / o_bright_peak for exactly
//    one cycle with o_valid high; the receiver cannot stall, busy drops in
//    the next cycle
//  - configuration writes on i_cfg_we / i_cfg_idx / i_cfg_data take effect
//    at once and belong in the idle time between frames
//  - reset clears the histogram, the held threshold and the frame state and
//    loads the register defaults 100, 254, 150 and 10
module histogram_bimodal_threshold (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [7:0]                i_pixel,
    input  logic                      i_frame_last,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [hbt_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_valid,
    output logic [7:0]                o_threshold,
    output logic [7:0]                o_dark_peak,
    output logic [7:0]                o_bright_peak
);
    import hbt_pkg::*;

    // command and status between controller and datapath
    t_cmd cmd;
    t_sts sts;

    hbt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_frame_last (i_frame_last),
        .i_sts        (sts),
        .o_cmd        (cmd),
        .o_busy       (busy),
        .o_valid      (o_valid)
    );

    hbt_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_pixel       (i_pixel),
        .i_frame_last  (i_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (t_cfg_idx'(i_cfg_idx)),
        .i_cfg_data    (i_cfg_data),
        .o_threshold   (o_threshold),
        .o_dark_peak   (o_dark_peak),
        .o_bright_peak (o_bright_peak)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// self-checking bench for histogram_bimodal_threshold: pixel frames in, peaks and threshold out
// holds its own histogram predictor and compares every frame result field by field
// depends on hbt_pkg and the rtl of the block
module testbench;
    import hbt_pkg::*;

    localparam int SETTLE      = 16;      // pixel pipe drain before a register write
    localparam int STALL_LIMIT = 25000;   // about ten times the slowest end-of-frame pass
    localparam int SEGMENTS    = 6;
    localparam int SEG_PIXELS  = 130;
    localparam int SEG_FRAMES  = 3;
    localparam int ROWS        = 26;

    typedef struct packed {
        logic [7:0] threshold;
        logic [7:0] dark_peak;
        logic [7:0] bright_peak;
    } t_frame_result;

    typedef struct packed {
        logic [7:0] dark_end;
        logic [7:0] bright_start;
        logic [7:0] bright_end;
        logic [7:0] patience;
    } t_scan_setting;

    typedef enum logic { ROW_PIXELS, ROW_WRITE } t_row_kind;

    typedef struct packed {
        t_row_kind     kind;
        t_cfg_idx      reg_sel;   // register for a write row
        logic [7:0]    value;     // grey level, or register value
        logic          last;      // last of the run closes the frame
        int            count;     // run length of equal pixels
        logic          typed;     // expectation given in the row
        t_frame_result want;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_pixel;
    logic       i_frame_last;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    logic       o_valid;
    logic [7:0] o_threshold;
    logic [7:0] o_dark_peak;
    logic [7:0] o_bright_peak;

    histogram_bimodal_threshold dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_pixel       (i_pixel),
        .i_frame_last  (i_frame_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_threshold   (o_threshold),
        .o_dark_peak   (o_dark_peak),
        .o_bright_peak (o_bright_peak)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // predictor state, mirrored from the ports
    logic [BIN_W-1:0] bin_count [BINS];
    logic [7:0]       kept_threshold;
    logic             frame_open;
    logic [7:0]       scan_dark_end;
    logic [7:0]       scan_bright_start;
    logic [7:0]       scan_bright_end;
    logic [7:0]       scan_patience;

    t_frame_result pending_results [$];   // frame results still owed by the block
    t_frame_result typed_results [$];     // hand-written expectations of directed frames

    int idle_pct;
    int mismatches;
    int pixels_taken;
    int pixels_driven;
    int frames_driven;
    int results_seen;
    int reg_writes;

    // bins above 255 read as empty, which covers the bright scan starting at 255
    function automatic int bin_level(int i);
        return (i < BINS) ? int'(bin_count[i]) : 0;
    endfunction

    // peak scans and balance search over the closed frame's histogram
    function automatic t_frame_result pick_threshold();
        int dark;
        int bright;
        int misses;
        int below;
        int above;
        int delta;
        int prev;
        t_frame_result r;
        dark   = 0;
        misses = 0;
        for (int i = 1; i < int'(scan_dark_end) && i < BINS; i++) begin
            if (bin_level(i) > bin_level(i - 1)) begin
                dark   = i;
                misses = 0;
            end else begin
                misses++;
            end
            if (misses > int'(scan_patience)) break;
        end
        bright = 255;
        misses = 0;
        // an empty range leaves the bright peak at its default
        for (int i = int'(scan_bright_start); i > int'(scan_bright_end); i--) begin
            if (bin_level(i) > bin_level(i + 1)) begin
                bright = i;
                misses = 0;
            end else begin
                misses++;
            end
            if (misses > int'(scan_patience)) break;
        end
        // crossed or equal peaks keep the previous threshold
        if (dark < bright) begin
            below = 0;
            above = 0;
            delta = int'(DELTA_START);
            for (int i = dark; i <= bright; i++) above += bin_level(i);
            for (int i = dark; i < bright; i++) begin
                below += bin_level(i);
                above -= bin_level(i);
                prev   = delta;
                delta  = above - below;
                if (delta < 0) delta = -delta;
                if (delta < prev) kept_threshold = 8'(i);
            end
        end
        r.threshold   = kept_threshold;
        r.dark_peak   = 8'(dark);
        r.bright_peak = 8'(bright);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_frame_result want,
                                 input t_frame_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     $time, what, want.threshold, want.dark_peak, want.bright_peak,
                     got.threshold, got.dark_peak, got.bright_peak);
    endtask

    // monitor: everything sampled at the edge that accepts it
    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        if (!i_rst_n) begin
            foreach (bin_count[b]) bin_count[b] = '0;
            kept_threshold    = '0;
            frame_open        = 1'b0;
            scan_dark_end     = DARK_END_RST;
            scan_bright_start = BRIGHT_START_RST;
            scan_bright_end   = BRIGHT_END_RST;
            scan_patience     = PATIENCE_RST;
        end else begin
            // results first, nothing can finish in the cycle its frame closes
            if (o_valid) begin
                got = '{o_threshold, o_dark_peak, o_bright_peak};
                results_seen++;
                if (pending_results.size() == 0) begin
                    note_mismatch("result with no frame pending", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got.threshold !== want.threshold
                        || got.dark_peak !== want.dark_peak
                        || got.bright_peak !== want.bright_peak)
                        note_mismatch("frame result", want, got);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DARK_END:     scan_dark_end     = i_cfg_data;
                    CFG_BRIGHT_START: scan_bright_start = i_cfg_data;
                    CFG_BRIGHT_END:   scan_bright_end   = i_cfg_data;
                    CFG_PATIENCE:     scan_patience     = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && busy === 1'b0) begin
                pixels_taken++;
                // the first pixel of a frame starts from an empty histogram
                if (!frame_open) foreach (bin_count[b]) bin_count[b] = '0;
                frame_open = 1'b1;
                if (bin_count[i_pixel] != BIN_MAX) bin_count[i_pixel]++;
                if (i_frame_last) begin
                    frame_open = 1'b0;
                    want = pick_threshold();
                    // directed frames with a hand-written answer use it instead
                    if (typed_results.size() != 0) want = typed_results.pop_front();
                    pending_results.push_back(want);
                end
            end
        end
    end

    // watchdog: ends the run after too long without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_valid === 1'b1) quiet = 0;
            else quiet++;
        end
        $display("watchdog: %0d cycles without a handshake", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // one pixel item, with a random gap in front of it
    task automatic drive_pixel(input logic [7:0] px, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_pixel      <= px;
        i_frame_last <= last;
        pixels_driven++;
        if (last) frames_driven++;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // holds the sender back until every owed result has come
    task automatic wait_idle(input int settle);
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx sel, input logic [7:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= val;
        reg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly two grey clusters per frame, sometimes flat noise
    task automatic drive_random_frame();
        int len;
        int lo_centre;
        int hi_centre;
        int spread;
        int px;
        logic two_modes;
        len       = ($urandom_range(9) == 0) ? int'($urandom_range(400, 100))
                                             : int'($urandom_range(40, 1));
        two_modes = ($urandom_range(3) != 0);
        lo_centre = int'($urandom_range(127));
        hi_centre = int'($urandom_range(255, 128));
        spread    = int'($urandom_range(15));
        for (int k = 0; k < len; k++) begin
            if (two_modes) begin
                px = ($urandom_range(1) != 0) ? hi_centre : lo_centre;
                px = px + int'($urandom_range(2 * spread)) - spread;
                if (px < 0) px = 0;
                if (px > 255) px = 255;
            end else begin
                px = int'($urandom_range(255));
            end
            drive_pixel(8'(px), k == len - 1);
        end
    endtask

    t_stim_row     stim_table [ROWS];
    t_scan_setting scan_settings [SEGMENTS];

    initial begin
        int seg_pixels;
        int seg_frames;
        start        <= 1'b0;
        i_pixel      <= '0;
        i_frame_last <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_DARK_END;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        idle_pct      = 11;
        mismatches    = 0;
        pixels_taken  = 0;
        pixels_driven = 0;
        frames_driven = 0;
        results_seen  = 0;
        reg_writes    = 0;

        stim_table = '{
            // single-pixel frames at the grey extremes, straight after reset
            '{ROW_PIXELS, CFG_DARK_END, 8'd0,   1'b1, 1, 1'b1, '{8'd0, 8'd0, 8'd255}},
            '{ROW_PIXELS, CFG_DARK_END, 8'd255, 1'b1, 1, 1'b1, '{8'd0, 8'd0, 8'd255}},
            // a clean two-peak frame under the reset settings
            '{ROW_PIXELS, CFG_DARK_END, 8'd20,  1'b0, 3, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd21,  1'b0, 5, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd22,  1'b0, 2, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd200, 1'b0, 4, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd201, 1'b0, 6, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd202, 1'b1, 1, 1'b0, '0},
            // one tall bin among short ones
            '{ROW_PIXELS, CFG_DARK_END, 8'd77,  1'b0, 100, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd5,   1'b0, 3, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd200, 1'b1, 1, 1'b0, '0},
            // bright scan from the top bin, empty neighbour above it
            '{ROW_WRITE,  CFG_BRIGHT_START, 8'd255, 1'b0, 0, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd255, 1'b0, 4, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd254, 1'b0, 2, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd10,  1'b1, 1, 1'b0, '0},
            // overlapping scans: crossed peaks, then equal peaks, threshold held
            '{ROW_WRITE,  CFG_DARK_END,     8'd255, 1'b0, 0, 1'b0, '0},
            '{ROW_WRITE,  CFG_BRIGHT_START, 8'd60,  1'b0, 0, 1'b0, '0},
            '{ROW_WRITE,  CFG_BRIGHT_END,   8'd0,   1'b0, 0, 1'b0, '0},
            '{ROW_WRITE,  CFG_PATIENCE,     8'd255, 1'b0, 0, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd40,  1'b0, 3, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd120, 1'b1, 2, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd50,  1'b1, 1, 1'b0, '0},
            // no patience: the first non-rise ends a scan
            '{ROW_WRITE,  CFG_PATIENCE,     8'd0,   1'b0, 0, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd1,   1'b0, 2, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd0,   1'b1, 1, 1'b0, '0},
            '{ROW_PIXELS, CFG_DARK_END, 8'd128, 1'b1, 3, 1'b0, '0}
        };

        // per segment: dark end, bright start, bright end, patience
        scan_settings = '{
            '{8'd2,   8'd1,   8'd0,   8'd0},     // narrowest scans
            '{8'd255, 8'd254, 8'd0,   8'd255},   // widest scans, slowest frames
            '{8'd160, 8'd80,  8'd100, 8'd3},     // empty bright range
            '{8'd30,  8'd254, 8'd253, 8'd20},    // single-step bright scan
            '{8'd100, 8'd254, 8'd150, 8'd10},    // reset values
            '0
        };
        scan_settings[5] = '{8'($urandom_range(255, 2)), 8'($urandom_range(254, 1)),
                             8'($urandom_range(253)), 8'($urandom_range(255))};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (stim_table[r]) begin
            if (stim_table[r].kind == ROW_WRITE) begin
                wait_idle(SETTLE);
                write_reg(stim_table[r].reg_sel, stim_table[r].value);
            end else begin
                for (int k = 0; k < stim_table[r].count; k++) begin
                    if (stim_table[r].typed && stim_table[r].last
                        && k == stim_table[r].count - 1)
                        typed_results.push_back(stim_table[r].want);
                    drive_pixel(stim_table[r].value,
                                stim_table[r].last && k == stim_table[r].count - 1);
                end
            end
        end

        // random part: sender gaps of 11 %, then 83 %, then none
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            idle_pct = (seg < 2) ? 11 : (seg < 4) ? 83 : 0;
            wait_idle(SETTLE);
            write_reg(CFG_DARK_END,     scan_settings[seg].dark_end);
            write_reg(CFG_BRIGHT_START, scan_settings[seg].bright_start);
            write_reg(CFG_BRIGHT_END,   scan_settings[seg].bright_end);
            write_reg(CFG_PATIENCE,     scan_settings[seg].patience);
            seg_pixels = pixels_driven;
            seg_frames = frames_driven;
            while (pixels_driven - seg_pixels < SEG_PIXELS
                   || frames_driven - seg_frames < SEG_FRAMES) begin
                drive_random_frame();
                // now and then hold off until the block has caught up
                if ($urandom_range(7) == 0) wait_idle(0);
            end
        end

        wait_idle(64);
        if (pending_results.size() != 0) begin
            $display("%0d frame results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("covered %0d pixel items in %0d frames, %0d frame results checked",
                 pixels_taken, frames_driven, results_seen);
        $display("register writes: %0d over %0d scan settings, held thresholds, tall bin",
                 reg_writes, SEGMENTS + 3);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
